[rtl/rgb_3x3_kernel_filter_core_macros.svh]
// ----------------------------------------------------------------------------
// RGB 3x3 kernel filter: assertion macros
// Shared property forms for the port checker of the filter core.
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_KERNEL_FILTER_CORE_MACROS_SVH
`define RGB_3X3_KERNEL_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RKF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rkf_pkg.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 kernel filter package
// Types, register codes and arithmetic constants shared by the filter files.
// ----------------------------------------------------------------------------
`default_nettype none

package rkf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CH_W       = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_LEFT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_RIGHT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_TOP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_BOTTOM    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL     = 3'd7;

  localparam logic [1:0] KERNEL_EDGE    = 2'd0;
  localparam logic [1:0] KERNEL_SHARPEN = 2'd1;
  localparam logic [1:0] KERNEL_BOX     = 2'd2;
  localparam logic [1:0] KERNEL_GAUSS   = 2'd3;

  // Box blur: floor(1111 * U / 10000) as (1111 * U) * ceil(2^36 / 10000) >> 36.
  // Exact for products below 2^22.
  localparam int BOX_TAP   = 1111;
  localparam int BOX_RECIP = 6871948;
  localparam int BOX_SHIFT = 36;

  typedef logic signed [12:0] rkf_sum_t;
  typedef logic [10:0]        rkf_val_t;
  typedef logic [21:0]        rkf_prod_t;
  typedef logic [44:0]        rkf_wide_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rkf_rgb_t;

  typedef struct packed {
    rkf_rgb_t top;
    rkf_rgb_t mid;
    rkf_rgb_t bot;
  } rkf_col_t;

  typedef struct packed {
    rkf_rgb_t up;
    rkf_rgb_t mid;
  } rkf_line_t;

  typedef struct packed {
    logic [1:0]      kernel;
    logic [CH_W-1:0] max_level;
  } rkf_kcfg_t;

  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } rkf_pix_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } rkf_res_t;

endpackage

`default_nettype wire

[rtl/rkf_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rkf_ram #(
  parameter int WIDTH = $bits(rkf_pkg::rkf_line_t),
  parameter int DEPTH = rkf_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/rkf_cell.sv]
// ----------------------------------------------------------------------------
// Window cell
// Holds one three-pixel column of the neighborhood and hands it on when the
// window shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module rkf_cell (
  input  logic              clk,
  input  logic              shift,
  input  rkf_pkg::rkf_col_t col_in,
  output rkf_pkg::rkf_col_t col
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

endmodule

`default_nettype wire

[rtl/rkf_chan.sv]
// ----------------------------------------------------------------------------
// Channel filter
// Three-stage kernel arithmetic for one color channel: tap sums, box-blur
// product, scaling and clamp into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rkf_chan (
  input  logic                                clk,
  input  logic                                en,
  input  rkf_pkg::rkf_kcfg_t                  kcfg,
  input  logic                                pass,
  input  logic [8:0][rkf_pkg::CH_W-1:0]       taps,
  output logic [rkf_pkg::CH_W-1:0]            level
);

  logic [9:0]                 corners;
  logic [9:0]                 edges;
  logic [rkf_pkg::CH_W-1:0]   ctr;
  rkf_pkg::rkf_sum_t          sum_next;
  rkf_pkg::rkf_sum_t          sum;
  logic                       pass3;
  logic [rkf_pkg::CH_W-1:0]   ctr3;
  rkf_pkg::rkf_val_t          val_next;
  rkf_pkg::rkf_prod_t         prod_next;
  rkf_pkg::rkf_val_t          val;
  rkf_pkg::rkf_prod_t         prod;
  logic                       pass4;
  logic [rkf_pkg::CH_W-1:0]   ctr4;
  rkf_pkg::rkf_wide_t         scaled;
  rkf_pkg::rkf_val_t          quot;
  logic [rkf_pkg::CH_W-1:0]   level_next;

  // Every kernel is symmetric, so the taps reduce to corners, edges and center.
  always_comb begin
    corners = 10'(taps[0]) + 10'(taps[2]) + 10'(taps[6]) + 10'(taps[8]);
    edges   = 10'(taps[1]) + 10'(taps[3]) + 10'(taps[5]) + 10'(taps[7]);
    ctr     = taps[4];
    case (kcfg.kernel)
      rkf_pkg::KERNEL_EDGE: begin
        sum_next = $signed({2'b00, ctr, 3'b000}) - $signed({3'b000, corners})
                   - $signed({3'b000, edges});
      end
      rkf_pkg::KERNEL_SHARPEN: begin
        sum_next = $signed({3'b000, ctr, 2'b00}) + $signed({5'b00000, ctr})
                   - $signed({3'b000, edges});
      end
      rkf_pkg::KERNEL_BOX: begin
        sum_next = $signed({3'b000, corners} + {3'b000, edges} + {5'b00000, ctr});
      end
      rkf_pkg::KERNEL_GAUSS: begin
        sum_next = $signed({3'b000, corners} + {2'b00, edges, 1'b0}
                   + {3'b000, ctr, 2'b00});
      end
      default: begin
        sum_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum   <= sum_next;
      pass3 <= pass;
      ctr3  <= ctr;
    end
  end

  // Edge and sharpen sums are whole multiples of the scale; gaussian is a
  // multiple of one sixteenth. Only the box blur needs a real division.
  always_comb begin
    prod_next = rkf_pkg::rkf_prod_t'(sum[11:0]) * rkf_pkg::rkf_prod_t'(rkf_pkg::BOX_TAP);
    case (kcfg.kernel)
      rkf_pkg::KERNEL_EDGE, rkf_pkg::KERNEL_SHARPEN: begin
        val_next = (sum[12] || sum == '0) ? '0 : sum[10:0];
      end
      rkf_pkg::KERNEL_GAUSS: begin
        val_next = rkf_pkg::rkf_val_t'(sum[11:4]);
      end
      default: begin
        val_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val   <= val_next;
      prod  <= prod_next;
      pass4 <= pass3;
      ctr4  <= ctr3;
    end
  end

  always_comb begin
    scaled = rkf_pkg::rkf_wide_t'(prod) * rkf_pkg::rkf_wide_t'(rkf_pkg::BOX_RECIP);
    quot   = (kcfg.kernel == rkf_pkg::KERNEL_BOX)
             ? rkf_pkg::rkf_val_t'(scaled >> rkf_pkg::BOX_SHIFT) : val;
    if (pass4) begin
      level_next = ctr4;
    end else if (quot > rkf_pkg::rkf_val_t'(kcfg.max_level)) begin
      level_next = kcfg.max_level;
    end else begin
      level_next = quot[rkf_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level <= level_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rgb_3x3_kernel_filter_core.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 kernel filter core
// Streaming 3x3 convolution of raster-order RGB pixels with one of four fixed
// kernels, border and selection passthrough, and flush-driven drain.
//
//   channel   direction   handshake               payload
//   pixel     in          pixel_valid/stall       rkf_pix_t
//   result    out         result_valid/stall      rkf_res_t
//   cfg       in          cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One pixel or flush is taken every clock while pixel_stall is low. A result
// passes the line store read, window shift, tap sum and box-blur product
// registers before it sits in the clamped output register.
// A result belongs to the item taken width+1 items earlier.
// Reset clears counters, valid flags and configuration registers; the line
// stores and pipeline data registers are not cleared.
// A held result under result_stall freezes every stage and raises
// pixel_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_3x3_kernel_filter_core #(
  parameter int MAX_WIDTH  = rkf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rkf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  rkf_pkg::rkf_pix_t                 pixel,
  output logic                              result_valid,
  input  logic                              result_stall,
  output rkf_pkg::rkf_res_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rkf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rkf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CMPC   = (COL_W + 1 > rkf_pkg::FW_W) ? COL_W + 1 : rkf_pkg::FW_W;
  localparam int ROW_HW = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = (ROW_HW > rkf_pkg::FH_W) ? ROW_HW : rkf_pkg::FH_W;
  localparam int CW     = rkf_pkg::CH_W;

  // Configuration registers.
  logic [1:0]              kernel_select;
  logic [rkf_pkg::FW_W-1:0] frame_width;
  logic [rkf_pkg::FH_W-1:0] frame_height;
  logic [rkf_pkg::FW_W-1:0] sel_left;
  logic [rkf_pkg::FW_W-1:0] sel_right;
  logic [rkf_pkg::FH_W-1:0] sel_top;
  logic [rkf_pkg::FH_W-1:0] sel_bottom;
  logic [CW-1:0]            max_level;

  // Position counters.
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  logic [CMPC-1:0]  fw_ext;
  logic [CMPC-1:0]  w;
  logic [CMPC-1:0]  w_m1;
  logic [ROW_W-1:0] fh_ext;
  logic [ROW_W-1:0] h;
  logic [ROW_W-1:0] h_m1;
  logic [CMPC-1:0]  col_inc;
  logic [CMPC-1:0]  oc;
  logic [CMPC-1:0]  oc_inc;
  logic [ROW_W-1:0] in_row_inc;
  logic [ROW_W-1:0] out_row_inc;
  logic [COL_W-1:0] in_col_next;
  logic [ROW_W-1:0] in_row_next;
  logic [COL_W-1:0] out_col_next;
  logic [ROW_W-1:0] out_row_next;

  logic              en;
  logic              accept;
  logic              done;
  logic              step;
  logic              primed;
  logic              pass;
  logic              last;
  rkf_pkg::rkf_rgb_t px;

  // Stage 1: line store read.
  logic              s1_valid;
  logic              s1_fwd;
  rkf_pkg::rkf_line_t s1_fwd_data;
  rkf_pkg::rkf_rgb_t s1_px;
  logic [COL_W-1:0]  s1_x;
  logic              s1_primed;
  logic              s1_pass;
  logic              s1_last;
  logic [$bits(rkf_pkg::rkf_line_t)-1:0] rd_data;
  rkf_pkg::rkf_line_t line;
  rkf_pkg::rkf_line_t wr_line;

  // Stage 2: window.
  logic              s2_valid;
  logic              s2_pass;
  logic              s2_last;
  rkf_pkg::rkf_col_t new_col;
  rkf_pkg::rkf_col_t win [3];

  logic              s3_valid;
  logic              s3_last;
  logic              s4_valid;
  logic              s4_last;
  logic              s5_last;

  rkf_pkg::rkf_kcfg_t       kcfg;
  logic [8:0][CW-1:0]       taps_r;
  logic [8:0][CW-1:0]       taps_g;
  logic [8:0][CW-1:0]       taps_b;
  logic [CW-1:0]            lvl_r;
  logic [CW-1:0]            lvl_g;
  logic [CW-1:0]            lvl_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= rkf_pkg::KERNEL_EDGE;
      frame_width   <= 11'd1024;
      frame_height  <= 13'd1;
      sel_left      <= '0;
      sel_right     <= 11'd1024;
      sel_top       <= '0;
      sel_bottom    <= 13'd4096;
      max_level     <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rkf_pkg::REG_KERNEL_SELECT: kernel_select <= cfg_data[1:0];
        rkf_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data[rkf_pkg::FW_W-1:0];
        rkf_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data[rkf_pkg::FH_W-1:0];
        rkf_pkg::REG_SEL_LEFT:      sel_left      <= cfg_data[rkf_pkg::FW_W-1:0];
        rkf_pkg::REG_SEL_RIGHT:     sel_right     <= cfg_data[rkf_pkg::FW_W-1:0];
        rkf_pkg::REG_SEL_TOP:       sel_top       <= cfg_data[rkf_pkg::FH_W-1:0];
        rkf_pkg::REG_SEL_BOTTOM:    sel_bottom    <= cfg_data[rkf_pkg::FH_W-1:0];
        rkf_pkg::REG_MAX_LEVEL:     max_level     <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;
  assign accept      = pixel_valid && en;

  // Frame geometry, position tests and counter steps.
  always_comb begin
    fw_ext = CMPC'(frame_width);
    if (frame_width == '0) begin
      w = CMPC'(1);
    end else if (fw_ext > CMPC'(MAX_WIDTH)) begin
      w = CMPC'(MAX_WIDTH);
    end else begin
      w = fw_ext;
    end
    fh_ext = ROW_W'(frame_height);
    if (frame_height == '0) begin
      h = ROW_W'(1);
    end else if (fh_ext > ROW_W'(MAX_HEIGHT)) begin
      h = ROW_W'(MAX_HEIGHT);
    end else begin
      h = fh_ext;
    end
    w_m1 = w - CMPC'(1);
    h_m1 = h - ROW_W'(1);

    done   = in_row >= h;
    step   = accept && (done || !pixel.command);
    primed = (in_row > ROW_W'(1)) || (in_row == ROW_W'(1) && in_col != '0);
    px     = done ? '0 : rkf_pkg::rkf_rgb_t'{red: pixel.in_red, green: pixel.in_green,
                                             blue: pixel.in_blue};

    // Row counters saturate; every bound they meet is at most the top value.
    col_inc     = CMPC'(in_col) + CMPC'(1);
    in_row_inc  = (in_row == '1) ? in_row : in_row + ROW_W'(1);
    in_col_next = (col_inc >= w) ? '0 : col_inc[COL_W-1:0];
    in_row_next = (col_inc >= w) ? in_row_inc : in_row;

    oc           = CMPC'(out_col);
    oc_inc       = oc + CMPC'(1);
    out_row_inc  = (out_row == '1) ? out_row : out_row + ROW_W'(1);
    out_col_next = (oc_inc >= w) ? '0 : oc_inc[COL_W-1:0];
    out_row_next = (oc_inc >= w) ? out_row_inc : out_row;

    pass = (out_row == '0) || (out_row >= h_m1) || (out_col == '0) || (oc >= w_m1)
           || (out_row < ROW_W'(sel_top)) || (out_row >= ROW_W'(sel_bottom))
           || (oc < CMPC'(sel_left)) || (oc >= CMPC'(sel_right));
    last = (out_row >= h_m1) && (oc >= w_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (step) begin
      if (primed && last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col <= in_col_next;
        in_row <= in_row_next;
        if (primed) begin
          out_col <= out_col_next;
          out_row <= out_row_next;
        end
      end
    end
  end

  // Both line stores share one address, so they live in one wide memory.
  rkf_ram #(
    .WIDTH ($bits(rkf_pkg::rkf_line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (en && s1_valid),
    .waddr (s1_x),
    .wdata (wr_line),
    .re    (en),
    .raddr (in_col),
    .rdata (rd_data)
  );

  // When the item ahead wrote the same column in the cycle this one was read,
  // the memory returned stale data; take the written value instead.
  assign line    = s1_fwd ? s1_fwd_data : rkf_pkg::rkf_line_t'(rd_data);
  assign wr_line = '{up: line.mid, mid: s1_px};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (en) begin
      s1_valid <= step;
      s1_fwd   <= s1_valid && (s1_x == in_col);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px       <= px;
      s1_x        <= in_col;
      s1_primed   <= primed;
      s1_pass     <= pass;
      s1_last     <= last;
      s1_fwd_data <= wr_line;
    end
  end

  assign new_col = '{top: line.up, mid: line.mid, bot: s1_px};

  rkf_cell u_cell_2 (
    .clk    (clk),
    .shift  (en && s1_valid),
    .col_in (new_col),
    .col    (win[2])
  );

  rkf_cell u_cell_1 (
    .clk    (clk),
    .shift  (en && s1_valid),
    .col_in (win[2]),
    .col    (win[1])
  );

  rkf_cell u_cell_0 (
    .clk    (clk),
    .shift  (en && s1_valid),
    .col_in (win[1]),
    .col    (win[0])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s2_valid     <= s1_valid && s1_primed;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      result_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pass <= s1_pass;
      s2_last <= s1_last;
      s3_last <= s2_last;
      s4_last <= s3_last;
      s5_last <= s4_last;
    end
  end

  // Tap k of the kernel is row k/3, column k%3 of the window.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      taps_r[j]     = win[j].top.red;
      taps_r[3 + j] = win[j].mid.red;
      taps_r[6 + j] = win[j].bot.red;
      taps_g[j]     = win[j].top.green;
      taps_g[3 + j] = win[j].mid.green;
      taps_g[6 + j] = win[j].bot.green;
      taps_b[j]     = win[j].top.blue;
      taps_b[3 + j] = win[j].mid.blue;
      taps_b[6 + j] = win[j].bot.blue;
    end
  end

  assign kcfg = '{kernel: kernel_select, max_level: max_level};

  rkf_chan u_chan_red (
    .clk   (clk),
    .en    (en),
    .kcfg  (kcfg),
    .pass  (s2_pass),
    .taps  (taps_r),
    .level (lvl_r)
  );

  rkf_chan u_chan_green (
    .clk   (clk),
    .en    (en),
    .kcfg  (kcfg),
    .pass  (s2_pass),
    .taps  (taps_g),
    .level (lvl_g)
  );

  rkf_chan u_chan_blue (
    .clk   (clk),
    .en    (en),
    .kcfg  (kcfg),
    .pass  (s2_pass),
    .taps  (taps_b),
    .level (lvl_b)
  );

  assign result = '{out_red: lvl_r, out_green: lvl_g, out_blue: lvl_b, frame_end: s5_last};

endmodule

`default_nettype wire

[rtl/rkf_checker.sv]
// ----------------------------------------------------------------------------
// RGB 3x3 kernel filter port checker
// Watches the ports of the filter core over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_3x3_kernel_filter_core_macros.svh"

module rkf_checker (
  input logic              clk,
  input logic              rst,
  input logic              pixel_stall,
  input logic              result_valid,
  input logic              result_stall,
  input rkf_pkg::rkf_res_t result,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  // A result that is not taken must stay on the port unchanged.
  `RKF_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  // Reset empties the pipeline: no result is valid in the cycle after reset.
  `RKF_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !result_valid, "result valid right after reset")

  // The input side is only held back by a result waiting at the output.
  `RKF_ASSERT_NOW(a_stall_source, clk, rst, pixel_stall, result_valid && result_stall, "pixel stall without a blocked result")

  // Register writes are always taken.
  `RKF_ASSERT_NOW(a_cfg_taken, clk, rst, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind rgb_3x3_kernel_filter_core rkf_checker u_rkf_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire
